// ----- src/rpvg_pkg.sv -----
// Shared types, constants and the arctangent table for the polygon vertex generator.
// No dependencies; imported by rpvg_cordic and regular_polygon_vertex_generator.
`default_nettype none

package rpvg_pkg;

  // input field widths
  localparam int SIDE_W   = 6;
  localparam int RADIUS_W = 15;
  localparam int ANGLE_W  = 16;
  localparam int COORD_W  = 16;

  // CORDIC datapath: x and y carry 30 fraction bits plus headroom, z holds 32-bit turn units
  localparam int CORDIC_W    = 34;
  localparam int TRIG_W      = 17;  // Q1.15 with one extra bit so that 1.0 is exact
  localparam int ATAN_IDX_W  = 5;
  localparam int ATAN_ENTRIES = 24;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  // step-angle division: full turn divided by the side count
  localparam int DIV_STEPS = 17;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_STEPS-1:0] FULL_TURN = 17'h10000;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } cordic_res_t;

  // atan(2^-i) in 32-bit turn units, rounded
  function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- src/rpvg_cordic.sv -----
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, then Q1.15 rounding
// and exact quadrant fold-back. Depends on rpvg_pkg.
`default_nettype none

module rpvg_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [rpvg_pkg::ANGLE_W-1:0]  angle,
  output rpvg_pkg::cordic_res_t              res
);
  import rpvg_pkg::*;

  localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  typedef enum logic [1:0] {C_IDLE, C_ROT, C_ROUND} cstate_t;
  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  cstate_t                     state;
  quad_t                       quad;
  logic [STEP_W-1:0]           step;
  logic signed [CORDIC_W-1:0]  x, y, z;
  logic signed [CORDIC_W-1:0]  x_next, y_next, z_next;
  logic signed [CORDIC_W-1:0]  dx, dy, at;
  logic [ANGLE_W-1:0]          biased, resid;
  logic [1:0]                  q_in;
  logic signed [TRIG_W-1:0]    xq, yq;
  logic signed [TRIG_W-1:0]    cos_next, sin_next;

  function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] r;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32768) begin
      return 17'sd32768;
    end else if (r < -34'sd32768) begin
      return -17'sd32768;
    end
    return r[TRIG_W-1:0];
  endfunction

  // quadrant split: residual lies within an eighth of a turn either side of zero
  assign biased = angle + 16'h2000;
  assign q_in   = biased[ANGLE_W-1 -: 2];
  assign resid  = angle - {q_in, 14'b0};

  assign dx = y >>> step;
  assign dy = x >>> step;
  assign at = {2'b00, atan_turn(ATAN_IDX_W'(step))};

  always_comb begin
    if (!z[CORDIC_W-1]) begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - at;
    end else begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + at;
    end
  end

  assign xq = to_q15(x);
  assign yq = to_q15(y);

  always_comb begin
    case (quad)
      QUAD_0: begin
        cos_next = xq;
        sin_next = yq;
      end
      QUAD_1: begin
        cos_next = -yq;
        sin_next = xq;
      end
      QUAD_2: begin
        cos_next = -xq;
        sin_next = -yq;
      end
      default: begin
        cos_next = yq;
        sin_next = -xq;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= C_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= (state == C_ROUND);
      case (state)
        C_IDLE: begin
          if (start) begin
            quad  <= quad_t'(q_in);
            x     <= CORDIC_GAIN_Q30;
            y     <= '0;
            z     <= {{2{resid[ANGLE_W-1]}}, resid, 16'b0};
            step  <= '0;
            state <= C_ROT;
          end
        end
        C_ROT: begin
          x <= x_next;
          y <= y_next;
          z <= z_next;
          if (step == STEP_W'(CORDIC_STEPS - 1)) begin
            state <= C_ROUND;
          end else begin
            step <= step + 1'b1;
          end
        end
        C_ROUND: begin
          res.cos_v <= cos_next;
          res.sin_v <= sin_next;
          state     <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) res.done |=> !res.done)
    else $error("cordic done held longer than one cycle");
  a_done_from_round: assert property (@(posedge clk) disable iff (rst)
      res.done |-> $past(state) == C_ROUND)
    else $error("cordic done without a rounding cycle");
  a_trig_range: assert property (@(posedge clk) disable iff (rst)
      res.done |-> (res.cos_v >= -17'sd32768 && res.cos_v <= 17'sd32768 &&
                    res.sin_v >= -17'sd32768 && res.sin_v <= 17'sd32768))
    else $error("cordic result outside unit range");

endmodule

`default_nettype wire

// ----- src/regular_polygon_vertex_generator.sv -----
// Top level of the regular polygon vertex generator: request intake, step-angle divider,
// vertex sequencer, coordinate scaling and output register. Depends on rpvg_pkg, rpvg_cordic.
//
// One request (side count n, radius, tilt, centre) yields n+1 vertices, the closing one
// repeating vertex 0 and flagged with tlast; side count 0 counts as 1 and counts above
// MAX_SIDES are clamped. After intake, a bit-serial division of a full turn by n gives the step
// angle. Each vertex then goes through the shared CORDIC unit, which does one micro-rotation per
// cycle, and through one shared multiplier used for x and then y. The next vertex is computed
// while the previous one waits in the output register; s_axis_tready is high only between
// requests.
`default_nettype none

module regular_polygon_vertex_generator #(
  parameter int MAX_SIDES    = 63,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // side_count[5:0], radius[20:6], tilt_angle[36:21], centre_x[52:37], centre_y[68:53]
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // vertex_x[15:0], vertex_y[31:16]
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tlast
);
  import rpvg_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_START, S_WAIT, S_MULX, S_MULY, S_FIN} state_t;

  state_t                    state;
  logic [SIDE_W-1:0]         n_eff;
  logic [RADIUS_W-1:0]       radius;
  logic [ANGLE_W-1:0]        tilt;
  logic signed [COORD_W-1:0] cx, cy;

  logic [DIV_STEPS-1:0]      quo;
  logic [SIDE_W-1:0]         rem;
  logic [DIV_CNT_W-1:0]      div_count;
  logic [SIDE_W:0]           rem_shift, rem_diff;
  logic                      qbit;

  logic [ANGLE_W-1:0]        acc_q;
  logic [SIDE_W-1:0]         acc_r;
  logic [SIDE_W:0]           acc_r_sum;
  logic                      acc_wrap;
  logic [SIDE_W-1:0]         idx;

  logic signed [32:0]        prod;
  logic signed [COORD_W-1:0] vx;

  logic [SIDE_W-1:0]         side_in, side_nz, side_clamped;
  logic                      in_fire, out_free, last_now;
  logic                      cordic_start;
  logic [ANGLE_W-1:0]        cordic_angle;
  cordic_res_t               cres;

  function automatic logic signed [COORD_W-1:0] finish(input logic signed [COORD_W-1:0] c,
                                                       input logic signed [32:0] p);
    logic signed [33:0] total;
    logic signed [33:0] q;
    total = {{3{c[COORD_W-1]}}, c, 15'b0} + {p[32], p};
    // truncate toward zero
    q = total[33] ? ((total + 34'sd32767) >>> 15) : (total >>> 15);
    if (q > 34'sd32767) begin
      return 16'sh7FFF;
    end else if (q < -34'sd32768) begin
      return 16'sh8000;
    end
    return q[COORD_W-1:0];
  endfunction

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign side_in      = s_axis_tdata[5:0];
  assign side_nz      = (side_in == '0) ? SIDE_W'(1) : side_in;
  assign side_clamped = (side_nz > SIDE_W'(MAX_SIDES)) ? SIDE_W'(MAX_SIDES) : side_nz;

  // restoring division of a full turn by n, one quotient bit per cycle
  assign rem_shift = {rem, quo[DIV_STEPS-1]};
  assign qbit      = (rem_shift >= {1'b0, n_eff});
  assign rem_diff  = rem_shift - {1'b0, n_eff};

  // running floor(i*65536/n): add quotient and remainder of the step, carry on wrap
  assign acc_r_sum = {1'b0, acc_r} + {1'b0, rem};
  assign acc_wrap  = (acc_r_sum >= {1'b0, n_eff});
  assign last_now  = (idx == n_eff);

  assign cordic_start = (state == S_START);
  assign cordic_angle = tilt + acc_q;

  rpvg_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(cordic_start),
    .angle(cordic_angle),
    .res  (cres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      // drop the vertex once taken, unless a new one replaces it this cycle
      if (m_axis_tvalid && m_axis_tready && state != S_FIN) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            n_eff     <= side_clamped;
            radius    <= s_axis_tdata[20:6];
            tilt      <= s_axis_tdata[36:21];
            cx        <= s_axis_tdata[52:37];
            cy        <= s_axis_tdata[68:53];
            quo       <= FULL_TURN;
            rem       <= '0;
            div_count <= '0;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= qbit ? rem_diff[SIDE_W-1:0] : rem_shift[SIDE_W-1:0];
          quo <= {quo[DIV_STEPS-2:0], qbit};
          if (div_count == DIV_CNT_W'(DIV_STEPS - 1)) begin
            acc_q <= '0;
            acc_r <= '0;
            idx   <= '0;
            state <= S_START;
          end else begin
            div_count <= div_count + 1'b1;
          end
        end
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (cres.done) begin
            state <= S_MULX;
          end
        end
        S_MULX: begin
          prod  <= $signed({1'b0, radius}) * cres.cos_v;
          state <= S_MULY;
        end
        S_MULY: begin
          prod  <= $signed({1'b0, radius}) * cres.sin_v;
          vx    <= finish(cx, prod);
          state <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            m_axis_tvalid       <= 1'b1;
            m_axis_tdata[15:0]  <= vx;
            m_axis_tdata[31:16] <= finish(cy, prod);
            m_axis_tlast        <= last_now;
            if (last_now) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              acc_r <= acc_wrap ? SIDE_W'(acc_r_sum - {1'b0, n_eff}) : acc_r_sum[SIDE_W-1:0];
              acc_q <= acc_q + quo[ANGLE_W-1:0] + {{(ANGLE_W-1){1'b0}}, acc_wrap};
              state <= S_START;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_side_range: assert property (@(posedge clk) disable iff (rst)
      (state == S_DIV) |-> (n_eff != '0 && n_eff <= SIDE_W'(MAX_SIDES)))
    else $error("side count out of range in divider");
  a_rem_below_n: assert property (@(posedge clk) disable iff (rst)
      (state == S_START) |-> (acc_r < n_eff && idx <= n_eff))
    else $error("angle accumulator remainder or vertex index out of range");
  a_closing_angle: assert property (@(posedge clk) disable iff (rst)
      (state == S_START && idx == n_eff) |-> (acc_q == '0 && acc_r == '0))
    else $error("closing vertex does not land on the first vertex");
  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
      cres.done |-> (state == S_WAIT))
    else $error("cordic result outside the wait state");

endmodule

`default_nettype wire
